// ----- rtl/clbo_pkg.sv -----
// shared types and constants for the level-order search tree unit
`timescale 1ns / 1ps
package clbo_pkg;

    localparam int unsigned MAX_KEYS_DEF = 64;
    localparam int unsigned KEY_W        = 32;

    // one queued input transaction
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic                    fin;
    } t_item;

    // back-end sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_BLD_DOWN,
        S_BLD_RD,
        S_BLD_WR,
        S_BLD_UP,
        S_EMT_RD,
        S_EMT_PUSH
    } t_state;

endpackage

// ----- rtl/complete_bst_level_order_unit.sv -----
// top level of the complete search tree level-order unit
`timescale 1ns / 1ps
// Keys enter through a two-entry queue and are sorted into a store one at a
// time: an insert reads and compares each stored key it moves past, one at a
// time through the single read port of the key store. After the key flagged
// final, the keys are placed by an in-order walk of the heap slots and then
// emitted in level order, one result at a time as pop takes them. The next
// batch's keys queue meanwhile.
module complete_bst_level_order_unit
    import clbo_pkg::*;
#(
    parameter int unsigned MAX_KEYS = MAX_KEYS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic signed [KEY_W-1:0] i_key_in,
    input  logic                    i_final_key,
    output logic                    empty,
    input  logic                    pop,
    output logic signed [KEY_W-1:0] o_key_out,
    output logic                    o_last_out,
    output logic                    o_overflowed
);

    t_item w_in_item;
    t_item w_q_item;
    logic  w_q_vld;
    logic  w_take;

    assign w_in_item.key = i_key_in;
    assign w_in_item.fin = i_final_key;

    // front: input transaction queue
    clbo_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (push),
        .i_wdata (w_in_item),
        .o_full  (full),
        .i_rd    (w_take),
        .o_rdata (w_q_item),
        .o_vld   (w_q_vld)
    );

    // back: sort, place and emit
    clbo_core #(
        .MAX_KEYS (MAX_KEYS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vld        (w_q_vld),
        .i_item       (w_q_item),
        .o_take       (w_take),
        .o_empty      (empty),
        .i_pop        (pop),
        .o_key_out    (o_key_out),
        .o_last_out   (o_last_out),
        .o_overflowed (o_overflowed)
    );

endmodule

// ----- rtl/clbo_fifo.sv -----
// two-entry input queue between the front and the back part
`timescale 1ns / 1ps
module clbo_fifo
    import clbo_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_item i_wdata,
    output logic  o_full,
    input  logic  i_rd,
    output t_item o_rdata,
    output logic  o_vld
);

    t_item       r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        w_wr;
    logic        w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_vld   = (r_cnt != 2'd0);
    assign o_rdata = r_mem[r_rp];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && o_vld;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= ~r_wp;
            if (w_rd) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_wdata;
    end

endmodule

// ----- rtl/clbo_core.sv -----
// back part: sorted insert, in-order tree placement and level-order emission
`timescale 1ns / 1ps
module clbo_core
    import clbo_pkg::*;
#(
    parameter int unsigned MAX_KEYS = MAX_KEYS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  t_item                   i_item,
    output logic                    o_take,
    output logic                    o_empty,
    input  logic                    i_pop,
    output logic signed [KEY_W-1:0] o_key_out,
    output logic                    o_last_out,
    output logic                    o_overflowed
);

    localparam int unsigned AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int unsigned CW = $clog2(MAX_KEYS + 1);
    localparam logic [CW-1:0] C_MAX = CW'(MAX_KEYS);
    localparam logic [CW-1:0] C_ONE = CW'(1);

    t_state r_state, n_state;

    logic signed [KEY_W-1:0] r_key, n_key;
    logic                    r_fin, n_fin;
    logic [CW-1:0]           r_count, n_count;
    logic                    r_drop, n_drop;
    logic [CW-1:0]           r_j, n_j;
    logic [CW-1:0]           r_slot, n_slot;
    logic [CW-1:0]           r_pos, n_pos;
    logic [CW-1:0]           r_s, n_s;
    logic                    r_out_vld, n_out_vld;
    logic signed [KEY_W-1:0] r_out_key, n_out_key;
    logic                    r_out_last, n_out_last;
    logic                    r_out_ovf, n_out_ovf;

    // memory ports
    logic signed [KEY_W-1:0] r_store [MAX_KEYS];
    logic signed [KEY_W-1:0] r_tree  [MAX_KEYS];
    logic signed [KEY_W-1:0] r_st_rd;
    logic signed [KEY_W-1:0] r_tr_rd;
    logic [AW-1:0]           w_st_ra, w_st_wa, w_tr_ra, w_tr_wa;
    logic                    w_st_we, w_tr_we;
    logic signed [KEY_W-1:0] w_st_wd;

    logic [CW:0]             w_left;
    logic [CW:0]             w_right;
    logic [CW:0]             w_n;
    logic                    w_cmp_gt;
    logic                    w_pos_end;
    logic                    w_s_last;

    assign w_left    = {r_slot, 1'b0};
    assign w_right   = {r_slot, 1'b1};
    assign w_n       = {1'b0, r_count};
    assign w_cmp_gt  = (r_st_rd > r_key);
    assign w_pos_end = ((r_pos + C_ONE) == r_count);
    assign w_s_last  = (r_s == r_count);

    assign o_empty      = !r_out_vld;
    assign o_key_out    = r_out_key;
    assign o_last_out   = r_out_last;
    assign o_overflowed = r_out_ovf;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_vld) begin
                    if (r_count == C_MAX) n_state = i_item.fin ? S_BLD_DOWN : S_IDLE;
                    else                  n_state = S_INS_RD;
                end
            end
            S_INS_RD: begin
                if (r_j == '0) n_state = r_fin ? S_BLD_DOWN : S_IDLE;
                else           n_state = S_INS_CMP;
            end
            S_INS_CMP: begin
                if (w_cmp_gt)   n_state = S_INS_RD;
                else if (r_fin) n_state = S_BLD_DOWN;
                else            n_state = S_IDLE;
            end
            S_BLD_DOWN: begin
                if (w_left > w_n) n_state = S_BLD_RD;
            end
            S_BLD_RD: n_state = S_BLD_WR;
            S_BLD_WR: begin
                if (w_pos_end)         n_state = S_EMT_RD;
                else if (w_right <= w_n) n_state = S_BLD_DOWN;
                else                   n_state = S_BLD_UP;
            end
            S_BLD_UP: begin
                if (!r_slot[0]) n_state = S_BLD_RD;
            end
            S_EMT_RD: begin
                if (!r_out_vld) n_state = S_EMT_PUSH;
            end
            S_EMT_PUSH: n_state = w_s_last ? S_IDLE : S_EMT_RD;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_key      = r_key;
        n_fin      = r_fin;
        n_count    = r_count;
        n_drop     = r_drop;
        n_j        = r_j;
        n_slot     = r_slot;
        n_pos      = r_pos;
        n_s        = r_s;
        n_out_vld  = r_out_vld && !i_pop;
        n_out_key  = r_out_key;
        n_out_last = r_out_last;
        n_out_ovf  = r_out_ovf;
        o_take     = 1'b0;
        w_st_ra    = r_j[AW-1:0] - AW'(1);
        w_st_wa    = r_j[AW-1:0];
        w_st_we    = 1'b0;
        w_st_wd    = r_key;
        w_tr_ra    = r_s[AW-1:0] - AW'(1);
        w_tr_wa    = r_slot[AW-1:0] - AW'(1);
        w_tr_we    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_vld) begin
                    o_take = 1'b1;
                    n_key  = i_item.key;
                    n_fin  = i_item.fin;
                    n_j    = r_count;
                    n_slot = C_ONE;
                    n_pos  = '0;
                    if (r_count == C_MAX) n_drop = 1'b1;
                end
            end
            S_INS_RD: begin
                if (r_j == '0) begin
                    w_st_we = 1'b1;
                    n_count = r_count + C_ONE;
                end
            end
            S_INS_CMP: begin
                w_st_we = 1'b1;
                if (w_cmp_gt) begin
                    w_st_wd = r_st_rd;
                    n_j     = r_j - C_ONE;
                end else begin
                    n_count = r_count + C_ONE;
                end
            end
            S_BLD_DOWN: begin
                if (w_left <= w_n) n_slot = w_left[CW-1:0];
            end
            S_BLD_RD: w_st_ra = r_pos[AW-1:0];
            S_BLD_WR: begin
                w_tr_we = 1'b1;
                n_pos   = r_pos + C_ONE;
                n_s     = C_ONE;
                if (w_right <= w_n) n_slot = w_right[CW-1:0];
            end
            S_BLD_UP: n_slot = r_slot >> 1;
            S_EMT_RD: ;
            S_EMT_PUSH: begin
                n_out_vld  = 1'b1;
                n_out_key  = r_tr_rd;
                n_out_last = w_s_last;
                n_out_ovf  = r_drop;
                n_s        = r_s + C_ONE;
                if (w_s_last) begin
                    n_count = '0;
                    n_drop  = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_drop    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_drop    <= n_drop;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_fin      <= n_fin;
        r_j        <= n_j;
        r_slot     <= n_slot;
        r_pos      <= n_pos;
        r_s        <= n_s;
        r_out_key  <= n_out_key;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    // sorted key store
    always_ff @(posedge i_clk) begin
        if (w_st_we) r_store[w_st_wa] <= w_st_wd;
        r_st_rd <= r_store[w_st_ra];
    end

    // tree store, indexed by heap slot
    always_ff @(posedge i_clk) begin
        if (w_tr_we) r_tree[w_tr_wa] <= r_st_rd;
        r_tr_rd <= r_tree[w_tr_ra];
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= C_MAX) else $error("key count beyond capacity");
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMT_PUSH |-> !r_out_vld) else $error("result register overrun");
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMT_PUSH && w_s_last) |=> (r_state == S_IDLE && r_count == '0))
        else $error("batch not cleared after last result");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> r_state == S_IDLE) else $error("item taken while busy");
`endif

endmodule

// ----- sim/tb_complete_bst_level_order_unit.sv -----
// testbench for the complete search tree level-order unit
`timescale 1ns / 1ps
module tb_complete_bst_level_order_unit;
    import clbo_pkg::*;

    localparam int unsigned NKEYS = 64;

    // one expected level-order result of a batch
    typedef struct {
        logic signed [KEY_W-1:0] key;
        logic                    last;
        logic                    ovf;
    } t_level_key;

    // scoreboard: sorted batch store and queue of expected level-order keys
    class level_order_board;
        logic signed [KEY_W-1:0] sorted_keys[$];
        logic                    dropped;
        t_level_key              pending[$];
        logic signed [KEY_W-1:0] slot_keys[NKEYS+1];
        int                      walk_pos;
        int                      checked;
        int                      batches;

        function new();
            dropped  = 1'b0;
            checked  = 0;
            batches  = 0;
        endfunction

        // in-order walk over heap slots fills the tree
        function void fill_slots(int slot, int n);
            if (slot > n || walk_pos >= n) return;
            fill_slots(2 * slot, n);
            if (walk_pos < n) begin
                slot_keys[slot] = sorted_keys[walk_pos];
                walk_pos++;
            end
            fill_slots(2 * slot + 1, n);
        endfunction

        // note one accepted input transaction
        function void note_key(logic signed [KEY_W-1:0] key, logic fin);
            int j;
            int n;
            t_level_key e;
            if (sorted_keys.size() < NKEYS) begin
                j = sorted_keys.size();
                while (j > 0 && sorted_keys[j-1] > key) j--;
                sorted_keys.insert(j, key);
            end else begin
                dropped = 1'b1;
            end
            if (!fin) return;
            n = sorted_keys.size();
            walk_pos = 0;
            fill_slots(1, n);
            for (int s = 1; s <= n; s++) begin
                e.key  = slot_keys[s];
                e.last = (s == n);
                e.ovf  = dropped;
                pending.push_back(e);
            end
            sorted_keys.delete();
            dropped = 1'b0;
            batches++;
        endfunction

        // check one accepted result transaction, returns mismatch text or ""
        function string check_key(logic signed [KEY_W-1:0] key, logic last, logic ovf);
            t_level_key e;
            checked++;
            if (pending.size() == 0) return "result with nothing expected";
            e = pending.pop_front();
            if (key !== e.key)
                return $sformatf("key_out %0d expected %0d", key, e.key);
            if (last !== e.last)
                return $sformatf("last_out %0b expected %0b", last, e.last);
            if (ovf !== e.ovf)
                return $sformatf("overflowed %0b expected %0b", ovf, e.ovf);
            return "";
        endfunction
    endclass

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    push;
    logic                    full;
    logic signed [KEY_W-1:0] i_key_in;
    logic                    i_final_key;
    logic                    empty;
    logic                    pop;
    logic signed [KEY_W-1:0] o_key_out;
    logic                    o_last_out;
    logic                    o_overflowed;

    level_order_board board;
    int  mismatches;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  hold_off;
    int  keys_sent;

    complete_bst_level_order_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_key_in    (i_key_in),
        .i_final_key (i_final_key),
        .empty       (empty),
        .pop         (pop),
        .o_key_out   (o_key_out),
        .o_last_out  (o_last_out),
        .o_overflowed(o_overflowed)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mismatch report
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    // offer one key, hold it until accepted, with random idle before it
    task automatic send_key(input logic signed [KEY_W-1:0] key, input logic fin);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push        <= 1'b1;
        i_key_in    <= key;
        i_final_key <= fin;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        board.note_key(key, fin);
        keys_sent++;
    endtask

    // random key with frequent extremes and duplicates
    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(9))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $signed(32'($urandom_range(7)) - 32'd4);
            default: return $signed($urandom());
        endcase
    endfunction

    // one batch of n keys, final flag on the last
    task automatic send_batch(input int n);
        for (int k = 0; k < n; k++) send_key(pick_key(), k == n - 1);
    endtask

    // result side: pop at random, check each accepted transaction
    always @(posedge i_clk) begin
        string msg;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                msg = board.check_key(o_key_out, o_last_out, o_overflowed);
                if (msg != "") report_mismatch(msg);
            end
            pop <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off counted in cycles
    task automatic hold_receiver(input int cycles);
        hold_off = 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_off = 1'b0;
    endtask

    // stop offering and wait until every expected result has come
    task automatic drain();
        push <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    // main sequence
    initial begin
        board          = new();
        mismatches     = 0;
        keys_sent      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off       = 1'b0;
        push           = 1'b0;
        i_key_in       = '0;
        i_final_key    = 1'b0;
        i_rst_n        = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single key extremes, sorted, reversed, duplicates
        send_key(32'sh8000_0000, 1'b1);
        send_key(32'sh7fff_ffff, 1'b1);
        send_key(32'sh0000_0000, 1'b0);
        send_key(-32'sd1, 1'b1);
        for (int k = 0; k < 5; k++) send_key(k, k == 4);
        for (int k = 0; k < 5; k++) send_key(10 - k, k == 4);
        for (int k = 0; k < 4; k++) send_key(7, k == 3);
        drain();

        // full store, then overflow on non-final and on final keys
        for (int k = 0; k < 64; k++) send_key(pick_key(), k == 63);
        for (int k = 0; k < 67; k++) send_key(pick_key(), k == 66);
        drain();

        // back-pressure: receiver holds off while sender keeps pushing
        fork
            hold_receiver(3000);
            begin
                send_batch(12);
                send_batch(12);
            end
        join
        drain();

        // random phases with various idle and stall mixes
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 3 ? 25 : 67) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 25 : 67) : 0;
            for (int b = 0; b < 6; b++) begin
                if ($urandom_range(15) == 0) send_batch($urandom_range(64, 66));
                else send_batch($urandom_range(1, 9));
            end
        end

        drain();
        repeat (300) @(posedge i_clk);
        $display("sent %0d keys in %0d batches, checked %0d level-order results",
                 keys_sent, board.batches, board.checked);
        $display("covered extremes, duplicates, full store, overflow and back-pressure");
        if (mismatches == 0 && board.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // run limit
    initial begin
        #20ms;
        $display("timeout");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- complete_bst_level_order_unit.f -----
rtl/clbo_pkg.sv
rtl/clbo_fifo.sv
rtl/clbo_core.sv
rtl/complete_bst_level_order_unit.sv
sim/tb_complete_bst_level_order_unit.sv
